// ----- rtl/wpf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard packet rule filter package
// Shared types, codes and the rule match function.
// ----------------------------------------------------------------------------
package wpf_pkg;

  // Default number of rule slots.
  localparam int RULE_SLOTS_DEF = 64;

  // Width of the rule count result field.
  localparam int RULES_HELD_W = 7;

  // Operation codes.
  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // Protocol numbers that carry transport ports.
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // Direction codes.
  localparam logic [1:0] DIR_IN  = 2'd1;
  localparam logic [1:0] DIR_OUT = 2'd2;

  // One stored rule. A zero field means any.
  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] port;
    logic [1:0]  direction;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  // One packet presented for classification.
  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [1:0]  direction;
  } pkt_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic wr_en;
    logic rd_en;
    logic ld_out;
    logic out_hit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic last;
  } dp_stat_t;

  // True when the rule matches the packet.
  function automatic logic rule_match(rule_t r, pkt_t p);
    logic dir_ok;
    logic src_ok;
    logic dst_ok;
    logic proto_ok;
    logic port_ok;
    logic has_ports;
    dir_ok    = !((r.direction == DIR_IN  && p.direction != DIR_IN) ||
                  (r.direction == DIR_OUT && p.direction != DIR_OUT));
    src_ok    = (r.src_ip == '0) || (r.src_ip == p.src_ip);
    dst_ok    = (r.dst_ip == '0) || (r.dst_ip == p.dst_ip);
    proto_ok  = (r.protocol == '0) || (r.protocol == p.protocol);
    has_ports = (p.protocol == PROTO_TCP) || (p.protocol == PROTO_UDP);
    port_ok   = (r.port == '0) ||
                (has_ports && ((p.src_port == r.port) || (p.dst_port == r.port)));
    return dir_ok && src_ok && dst_ok && proto_ok && port_ok;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/wpf_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/wpf_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rule filter controller
// Sequences add and classify transactions and owns the output valid flag.
// ----------------------------------------------------------------------------
module wpf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              op,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire wpf_pkg::dp_stat_t stat,
  output wpf_pkg::dp_cmd_t       cmd
);

  import wpf_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (op == OP_CLASSIFY) && !stat.empty) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = accept;
        if (accept && (op == OP_ADD)) begin
          cmd.wr_en  = !stat.full;
          cmd.ld_out = 1'b1;
        end else if (accept && stat.empty) begin
          cmd.ld_out = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
      end
      ST_FLUSH: begin
        cmd = '0;
      end
      ST_RESULT: begin
        cmd.ld_out  = out_free;
        cmd.out_hit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.ld_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/wpf_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rule filter datapath
// Rule memory, rule count, scan index, match logic and result registers.
// ----------------------------------------------------------------------------
module wpf_dp #(
  parameter int RULE_SLOTS = wpf_pkg::RULE_SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [31:0]                       src_ip,
  input  wire logic [31:0]                       dst_ip,
  input  wire logic [7:0]                        protocol,
  input  wire logic [15:0]                       src_port,
  input  wire logic [15:0]                       dst_port,
  input  wire logic [1:0]                        direction,
  input  wire logic [15:0]                       rule_port,
  input  wire wpf_pkg::dp_cmd_t                  cmd,
  output wpf_pkg::dp_stat_t                      stat,
  output logic                                   verdict,
  output logic                                   add_ok,
  output logic [wpf_pkg::RULES_HELD_W-1:0]       rules_held
);

  import wpf_pkg::*;

  localparam int AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CW = $clog2(RULE_SLOTS + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [AW-1:0] idx;
  logic          rd_vld;
  logic          hit;
  pkt_t          pkt;
  rule_t         wr_rule;
  rule_t         rd_rule;

  // New rule straight from the input fields.
  always_comb begin
    wr_rule.src_ip    = src_ip;
    wr_rule.dst_ip    = dst_ip;
    wr_rule.protocol  = protocol;
    wr_rule.port      = rule_port;
    wr_rule.direction = direction;
  end

  wpf_ram #(
    .WIDTH (RULE_W),
    .DEPTH (RULE_SLOTS)
  ) u_rules (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (count[AW-1:0]),
    .wdata (wr_rule),
    .re    (cmd.rd_en),
    .raddr (idx),
    .rdata (rd_rule)
  );

  // Rule count after the current transaction.
  assign count_next = count + CW'(cmd.wr_en);

  // Status for the controller.
  assign stat.full  = (count == CW'(RULE_SLOTS));
  assign stat.empty = (count == '0);
  assign stat.last  = ((CW'(idx) + CW'(1)) == count);

  // Rule count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Packet capture and scan index.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pkt.src_ip    <= src_ip;
      pkt.dst_ip    <= dst_ip;
      pkt.protocol  <= protocol;
      pkt.src_port  <= src_port;
      pkt.dst_port  <= dst_port;
      pkt.direction <= direction;
      idx           <= '0;
    end else if (cmd.rd_en) begin
      idx <= idx + AW'(1);
    end
  end

  // Read data valid flag and accumulated match.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      hit    <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      if (cmd.capture) begin
        hit <= 1'b0;
      end else if (rd_vld && rule_match(rd_rule, pkt)) begin
        hit <= 1'b1;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      verdict    <= cmd.out_hit && hit;
      add_ok     <= cmd.wr_en;
      rules_held <= RULES_HELD_W'(count_next);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/wildcard_packet_rule_filter_top.sv -----
`default_nettype none
// An add, or a classify on an empty table, shows its result in the cycle after
// it is accepted; adds are taken one per cycle while the output is not stalled.
// A classify runs the scan, flush and result states, reading one rule per cycle
// from the single rule memory port, and no input is taken until its result is
// loaded. Reset clears the rule count and output valid, not the rule memory.
// ----------------------------------------------------------------------------
// Wildcard packet rule filter
// Stores wildcard drop rules and classifies packets against them.
// ----------------------------------------------------------------------------
module wildcard_packet_rule_filter_top #(
  parameter int RULE_SLOTS = wpf_pkg::RULE_SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        op,
  input  wire logic [31:0]                 src_ip,
  input  wire logic [31:0]                 dst_ip,
  input  wire logic [7:0]                  protocol,
  input  wire logic [15:0]                 src_port,
  input  wire logic [15:0]                 dst_port,
  input  wire logic [1:0]                  direction,
  input  wire logic [15:0]                 rule_port,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             verdict,
  output logic                             add_ok,
  output logic [wpf_pkg::RULES_HELD_W-1:0] rules_held
);

  import wpf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing.
  wpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Rule storage and matching.
  wpf_dp #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .src_ip     (src_ip),
    .dst_ip     (dst_ip),
    .protocol   (protocol),
    .src_port   (src_port),
    .dst_port   (dst_port),
    .direction  (direction),
    .rule_port  (rule_port),
    .cmd        (cmd),
    .stat       (stat),
    .verdict    (verdict),
    .add_ok     (add_ok),
    .rules_held (rules_held)
  );

endmodule
`default_nettype wire

// ----- rtl/wpf_chk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rule filter port checker
// Watches the top level ports over time and flags illegal behavior.
// ----------------------------------------------------------------------------
module wpf_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic                        verdict,
  input wire logic                        add_ok,
  input wire logic [wpf_pkg::RULES_HELD_W-1:0] rules_held
);

  import wpf_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(add_ok) &&
      $stable(rules_held))
    else $error("stalled result changed");

  // No transaction is taken while a finished result is stuck.
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while output stalled");

  // A result is either a drop verdict or a stored rule, never both.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(verdict && add_ok))
    else $error("verdict and add_ok both set");

  // An accepted add that stored a rule reports a changed count.
  a_add_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && add_ok ##1 out_valid && add_ok |->
      rules_held != $past(rules_held))
    else $error("rule count did not advance on add");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind wildcard_packet_rule_filter_top wpf_chk u_chk (.*);
`default_nettype wire
